[design/deq_pkg.sv]
// Shared types, constants and codes of the double-ended queue unit.
`default_nettype none

package deq_pkg;

  // Storage geometry.
  localparam int Depth  = 1024;
  localparam int AddrW  = $clog2(Depth);
  localparam int CountW = $clog2(Depth + 1);
  localparam int DataW  = 32;
  localparam int OpW    = 3;

  // Depth of the command queue between the front and back parts.
  localparam int CmdQDepth = 2;
  localparam int CmdQPtrW  = $clog2(CmdQDepth);
  localparam int CmdQOccW  = $clog2(CmdQDepth + 1);

  // Widths of the packed result beat.
  localparam int ResW      = 3 * DataW + CountW + 1;
  localparam int OutDataW  = ((ResW + 7) / 8) * 8;
  localparam int OutPadW   = OutDataW - ResW;

  // Operation codes as they arrive on the input channel.
  localparam logic [OpW-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OpW-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OpW-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OpW-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OpW-1:0] OP_QUERY      = 3'd4;

  // Classified command kinds; every unused code becomes a query.
  typedef enum logic [2:0] {
    CMD_PUSH_FRONT,
    CMD_PUSH_BACK,
    CMD_POP_FRONT,
    CMD_POP_BACK,
    CMD_QUERY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic signed [DataW-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [DataW-1:0] popped;
    logic                    error;
    logic [CountW-1:0]       count;
    logic                    is_empty;
    logic signed [DataW-1:0] front;
    logic signed [DataW-1:0] back;
  } res_t;

  // Back part states.
  typedef enum logic {
    EX_IDLE,
    EX_FETCH
  } exec_state_t;

endpackage

`default_nettype wire

[design/deq_front.sv]
// Front part: accepts operation beats and classifies them into commands.
`default_nettype none

module deq_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [deq_pkg::OpW-1:0]        in_op,
  input  wire logic signed [deq_pkg::DataW-1:0] in_value,
  output logic                                cmd_valid,
  input  wire logic                           cmd_ready,
  output deq_pkg::cmd_t                       cmd
);

  deq_pkg::cmd_kind_t kind;

  // Map the operation code to a command kind.
  always_comb begin
    unique case (in_op)
      deq_pkg::OP_PUSH_FRONT: kind = deq_pkg::CMD_PUSH_FRONT;
      deq_pkg::OP_PUSH_BACK:  kind = deq_pkg::CMD_PUSH_BACK;
      deq_pkg::OP_POP_FRONT:  kind = deq_pkg::CMD_POP_FRONT;
      deq_pkg::OP_POP_BACK:   kind = deq_pkg::CMD_POP_BACK;
      deq_pkg::OP_QUERY:      kind = deq_pkg::CMD_QUERY;
      default:                kind = deq_pkg::CMD_QUERY;
    endcase
  end

  // The stage takes a new beat whenever it is empty or being drained.
  assign in_ready = !cmd_valid || cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_ready) begin
      cmd_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd.kind  <= kind;
      cmd.value <= in_value;
    end
  end

endmodule

`default_nettype wire

[design/deq_cmd_queue.sv]
// Short command queue that decouples the front part from the back part.
`default_nettype none

module deq_cmd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  input  wire deq_pkg::cmd_t wr_data,
  output logic               rd_valid,
  input  wire logic          rd_ready,
  output deq_pkg::cmd_t      rd_data
);

  deq_pkg::cmd_t                  entries [deq_pkg::CmdQDepth];
  logic [deq_pkg::CmdQPtrW-1:0]   wr_ptr;
  logic [deq_pkg::CmdQPtrW-1:0]   rd_ptr;
  logic [deq_pkg::CmdQOccW-1:0]   occ;
  logic                           do_wr;
  logic                           do_rd;

  assign wr_ready = occ != deq_pkg::CmdQOccW'(deq_pkg::CmdQDepth);
  assign rd_valid = occ != '0;
  assign rd_data  = entries[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      occ    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == deq_pkg::CmdQPtrW'(deq_pkg::CmdQDepth - 1)) ? '0
                  : wr_ptr + deq_pkg::CmdQPtrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == deq_pkg::CmdQPtrW'(deq_pkg::CmdQDepth - 1)) ? '0
                  : rd_ptr + deq_pkg::CmdQPtrW'(1);
      end
      if (do_wr && !do_rd) begin
        occ <= occ + deq_pkg::CmdQOccW'(1);
      end else if (do_rd && !do_wr) begin
        occ <= occ - deq_pkg::CmdQOccW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // The fill level never passes the number of entries.
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= deq_pkg::CmdQOccW'(deq_pkg::CmdQDepth))
    else $error("command queue overfilled");

endmodule

`default_nettype wire

[design/deq_exec.sv]
// Back part: ring buffer store, pointers, cached end words and result register.
`default_nettype none

module deq_exec (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire deq_pkg::cmd_t cmd,
  output logic               res_valid,
  input  wire logic          res_ready,
  output deq_pkg::res_t      res
);

  deq_pkg::exec_state_t state;
  deq_pkg::exec_state_t state_next;

  logic signed [deq_pkg::DataW-1:0] mem [deq_pkg::Depth];
  logic signed [deq_pkg::DataW-1:0] rdata;

  logic [deq_pkg::AddrW-1:0]        front_pos;
  logic [deq_pkg::AddrW-1:0]        front_pos_next;
  logic [deq_pkg::CountW-1:0]       item_count;
  logic [deq_pkg::CountW-1:0]       item_count_next;
  logic signed [deq_pkg::DataW-1:0] front_word;
  logic signed [deq_pkg::DataW-1:0] front_word_next;
  logic signed [deq_pkg::DataW-1:0] back_word;
  logic signed [deq_pkg::DataW-1:0] back_word_next;
  logic signed [deq_pkg::DataW-1:0] pend_popped;
  logic signed [deq_pkg::DataW-1:0] pend_popped_next;
  logic                             pend_front;
  logic                             pend_front_next;

  logic                             take;
  logic                             fetch_req;
  logic                             res_load;
  deq_pkg::res_t                    res_next;
  logic signed [deq_pkg::DataW-1:0] popped;
  logic                             err;

  logic                             mem_we;
  logic [deq_pkg::AddrW-1:0]        waddr;
  logic                             mem_re;
  logic [deq_pkg::AddrW-1:0]        raddr;

  logic                             is_full;
  logic                             is_emp;
  logic [deq_pkg::AddrW-1:0]        front_dec;
  logic [deq_pkg::AddrW-1:0]        front_inc;
  logic [deq_pkg::AddrW-1:0]        tail_idx;
  logic [deq_pkg::AddrW-1:0]        new_back_idx;

  // Ring position plus an offset of at most the depth, wrapped once.
  function automatic logic [deq_pkg::AddrW-1:0] ring_add(
    input logic [deq_pkg::AddrW-1:0]  pos,
    input logic [deq_pkg::CountW-1:0] off
  );
    logic [deq_pkg::CountW:0] s;
    s = (deq_pkg::CountW+1)'(pos) + (deq_pkg::CountW+1)'(off);
    if (s >= (deq_pkg::CountW+1)'(deq_pkg::Depth)) begin
      s = s - (deq_pkg::CountW+1)'(deq_pkg::Depth);
    end
    return s[deq_pkg::AddrW-1:0];
  endfunction

  // Ring positions around the current front and back.
  always_comb begin
    is_full      = item_count == deq_pkg::CountW'(deq_pkg::Depth);
    is_emp       = item_count == '0;
    front_dec    = (front_pos == '0) ? deq_pkg::AddrW'(deq_pkg::Depth - 1)
                   : front_pos - deq_pkg::AddrW'(1);
    front_inc    = ring_add(front_pos, deq_pkg::CountW'(1));
    tail_idx     = ring_add(front_pos, item_count);
    new_back_idx = ring_add(front_pos, item_count - deq_pkg::CountW'(2));
  end

  // Next state: a pop that leaves words behind waits in EX_FETCH for the store.
  always_comb begin
    state_next = state;
    unique case (state)
      deq_pkg::EX_IDLE: begin
        if (fetch_req) state_next = deq_pkg::EX_FETCH;
      end
      deq_pkg::EX_FETCH: state_next = deq_pkg::EX_IDLE;
      default:           state_next = deq_pkg::EX_IDLE;
    endcase
  end

  // Command execution, store access and result assembly.
  always_comb begin
    cmd_ready        = (state == deq_pkg::EX_IDLE) && (!res_valid || res_ready);
    take             = cmd_valid && cmd_ready;
    mem_we           = 1'b0;
    waddr            = front_dec;
    mem_re           = 1'b0;
    raddr            = front_inc;
    front_pos_next   = front_pos;
    item_count_next  = item_count;
    front_word_next  = front_word;
    back_word_next   = back_word;
    pend_popped_next = pend_popped;
    pend_front_next  = pend_front;
    fetch_req        = 1'b0;
    res_load         = 1'b0;
    popped           = '0;
    err              = 1'b0;

    if (state == deq_pkg::EX_FETCH) begin
      // The new end word has arrived from the store.
      if (pend_front) begin
        front_word_next = rdata;
      end else begin
        back_word_next = rdata;
      end
      popped   = pend_popped;
      res_load = 1'b1;
    end else if (take) begin
      res_load = 1'b1;
      unique case (cmd.kind)
        deq_pkg::CMD_PUSH_FRONT: begin
          if (is_full) begin
            err = 1'b1;
          end else begin
            mem_we          = 1'b1;
            waddr           = front_dec;
            front_pos_next  = front_dec;
            item_count_next = item_count + deq_pkg::CountW'(1);
            front_word_next = cmd.value;
            if (is_emp) back_word_next = cmd.value;
          end
        end
        deq_pkg::CMD_PUSH_BACK: begin
          if (is_full) begin
            err = 1'b1;
          end else begin
            mem_we          = 1'b1;
            waddr           = tail_idx;
            item_count_next = item_count + deq_pkg::CountW'(1);
            back_word_next  = cmd.value;
            if (is_emp) front_word_next = cmd.value;
          end
        end
        deq_pkg::CMD_POP_FRONT: begin
          if (is_emp) begin
            err = 1'b1;
          end else begin
            popped          = front_word;
            front_pos_next  = front_inc;
            item_count_next = item_count - deq_pkg::CountW'(1);
            if (item_count != deq_pkg::CountW'(1)) begin
              mem_re           = 1'b1;
              raddr            = front_inc;
              fetch_req        = 1'b1;
              res_load         = 1'b0;
              pend_popped_next = front_word;
              pend_front_next  = 1'b1;
            end
          end
        end
        deq_pkg::CMD_POP_BACK: begin
          if (is_emp) begin
            err = 1'b1;
          end else begin
            popped          = back_word;
            item_count_next = item_count - deq_pkg::CountW'(1);
            if (item_count != deq_pkg::CountW'(1)) begin
              mem_re           = 1'b1;
              raddr            = new_back_idx;
              fetch_req        = 1'b1;
              res_load         = 1'b0;
              pend_popped_next = back_word;
              pend_front_next  = 1'b0;
            end
          end
        end
        default: begin
          // A query leaves everything as it is.
        end
      endcase
    end

    res_next.popped   = popped;
    res_next.error    = err;
    res_next.count    = item_count_next;
    res_next.is_empty = item_count_next == '0;
    res_next.front    = (item_count_next == '0) ? '0 : front_word_next;
    res_next.back     = (item_count_next == '0) ? '0 : back_word_next;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= deq_pkg::EX_IDLE;
      front_pos  <= '0;
      item_count <= '0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      front_pos  <= front_pos_next;
      item_count <= item_count_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    front_word  <= front_word_next;
    back_word   <= back_word_next;
    pend_popped <= pend_popped_next;
    pend_front  <= pend_front_next;
    if (res_load) begin
      res <= res_next;
    end
  end

  // Ring buffer store with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= cmd.value;
    end
    if (mem_re) begin
      rdata <= mem[raddr];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    item_count <= deq_pkg::CountW'(deq_pkg::Depth))
    else $error("element count beyond capacity");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!res_valid || res_ready))
    else $error("result register overwritten before it was taken");

  a_fetch_once: assert property (@(posedge clk) disable iff (rst)
    (state == deq_pkg::EX_FETCH) |=> (state == deq_pkg::EX_IDLE) && $past(res_load))
    else $error("store fetch did not complete in one cycle");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.is_empty == (res.count == '0)))
    else $error("empty flag disagrees with count");

endmodule

`default_nettype wire

[design/double_ended_queue_unit.sv]
// Top level of the double-ended queue unit: front part, command queue, back part.
//
// Input channel s_axis: one beat is one operation. tuser carries the operation
// code (push front, push back, pop front, pop back, query; other codes query),
// tdata the 32-bit word to push. Output channel m_axis: one result beat for
// every operation, in order. tuser is the error flag (pop on an empty queue or
// push on a full one); tdata holds the popped word, the element count, the
// empty flag and the front and back words after the operation.
// An operation passes the front stage, the command queue and the result register;
// a pop that leaves words behind also waits in the fetch state for the new end
// word from the store's registered read port, and the back part takes no command meanwhile.
// Pushes, queries and failed operations sustain one beat per cycle while results are taken.
// Reset empties the queue at once; no clearing pass runs, since a store entry
// is read only after it has been written. When the receiver stalls, the result
// register holds, and the front part keeps taking beats until the two-entry
// command queue and its own stage are full, then drops s_axis_tready.
`default_nettype none

module double_ended_queue_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [deq_pkg::DataW-1:0]     s_axis_tdata,  // [31:0] value
  input  wire logic [deq_pkg::OpW-1:0]       s_axis_tuser,  // [2:0] op
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [31:0] popped_value, [42:32] count, [43] is_empty, [75:44] front_value,
  // [107:76] back_value, [111:108] zero
  output logic [deq_pkg::OutDataW-1:0]       m_axis_tdata,
  output logic                               m_axis_tuser   // [0] error
);

  logic          fr_valid;
  logic          fr_ready;
  deq_pkg::cmd_t fr_cmd;
  logic          q_valid;
  logic          q_ready;
  deq_pkg::cmd_t q_cmd;
  deq_pkg::res_t res;

  deq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tuser),
    .in_value  (s_axis_tdata),
    .cmd_valid (fr_valid),
    .cmd_ready (fr_ready),
    .cmd       (fr_cmd)
  );

  deq_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_data  (fr_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_cmd)
  );

  deq_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  // Pack the result beat, first field in the lowest bits.
  assign m_axis_tdata = {{deq_pkg::OutPadW{1'b0}}, res.back, res.front, res.is_empty,
                         res.count, res.popped};
  assign m_axis_tuser = res.error;

endmodule

`default_nettype wire

[test/deq_result_checker.sv]
// Checker that predicts every result beat of the double-ended queue unit and compares it.
module deq_result_checker
  import deq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [DataW-1:0]    s_axis_tdata,
  input  logic [OpW-1:0]      s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic                m_axis_tuser,
  output int                  mismatch_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the ring buffer: word store, index of the first word and fill level.
  logic [DataW-1:0] ring [Depth];
  int               head;
  int               level;

  // Results predicted for accepted operations, oldest first.
  res_t expected_results [$];
  int   errs;

  initial begin
    mismatch_count = 0;
    pending        = 0;
    errs           = 0;
    head           = 0;
    level          = 0;
  end

  // Performs one operation on the shadow queue and returns the result it should give.
  function automatic res_t apply_deque_op(input logic [OpW-1:0] op,
                                          input logic [DataW-1:0] word);
    res_t      r;
    cmd_kind_t kind;
    r = '0;
    case (op)
      OP_PUSH_FRONT: kind = CMD_PUSH_FRONT;
      OP_PUSH_BACK:  kind = CMD_PUSH_BACK;
      OP_POP_FRONT:  kind = CMD_POP_FRONT;
      OP_POP_BACK:   kind = CMD_POP_BACK;
      default:       kind = CMD_QUERY;
    endcase
    case (kind)
      CMD_PUSH_FRONT: begin
        if (level >= Depth) begin
          r.error = 1'b1;
        end else begin
          head       = (head + Depth - 1) % Depth;
          ring[head] = word;
          level++;
        end
      end
      CMD_PUSH_BACK: begin
        if (level >= Depth) begin
          r.error = 1'b1;
        end else begin
          ring[(head + level) % Depth] = word;
          level++;
        end
      end
      CMD_POP_FRONT: begin
        if (level == 0) begin
          r.error = 1'b1;
        end else begin
          r.popped = ring[head];
          head     = (head + 1) % Depth;
          level--;
        end
      end
      CMD_POP_BACK: begin
        if (level == 0) begin
          r.error = 1'b1;
        end else begin
          r.popped = ring[(head + level - 1) % Depth];
          level--;
        end
      end
      default: ;
    endcase
    r.count    = level[CountW-1:0];
    r.is_empty = (level == 0);
    if (level != 0) begin
      r.front = ring[head];
      r.back  = ring[(head + level - 1) % Depth];
    end
    return r;
  endfunction

  // Reports one field that differs from its prediction.
  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errs++;
    end
  endtask

  // Result beats are checked before operation beats of the same edge, since no
  // result can belong to an operation accepted at that very edge.
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      head  = 0;
      level = 0;
      expected_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.popped   = m_axis_tdata[0 +: DataW];
        got.count    = m_axis_tdata[DataW +: CountW];
        got.is_empty = m_axis_tdata[DataW + CountW];
        got.front    = m_axis_tdata[DataW + CountW + 1 +: DataW];
        got.back     = m_axis_tdata[2 * DataW + CountW + 1 +: DataW];
        got.error    = m_axis_tuser;
        if (expected_results.size() == 0) begin
          $error("result beat with no operation waiting for it");
          errs++;
        end else begin
          want = expected_results.pop_front();
          check_field("popped_value", longint'(want.popped), longint'(got.popped));
          check_field("error", longint'(want.error), longint'(got.error));
          check_field("count", longint'(want.count), longint'(got.count));
          check_field("is_empty", longint'(want.is_empty), longint'(got.is_empty));
          check_field("front_value", longint'(want.front), longint'(got.front));
          check_field("back_value", longint'(want.back), longint'(got.back));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(apply_deque_op(s_axis_tuser, s_axis_tdata));
      end
    end
    mismatch_count <= errs;
    pending        <= expected_results.size();
  end

endmodule

[test/tb_double_ended_queue_unit.sv]
// Testbench top of the double-ended queue unit: clock, reset, operation stimulus and verdict.
module tb_double_ended_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import deq_pkg::*;

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [DataW-1:0]    s_axis_tdata  = '0;
  logic [OpW-1:0]      s_axis_tuser  = OP_QUERY;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  int                  mismatch_count;
  int                  pending;

  // Fill level as the stimulus sees it, used only to steer the random phases.
  int level = 0;
  int sent  = 0;

  always #6 clk = ~clk;

  double_ended_queue_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  deq_result_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Word to push, with the extremes turning up often.
  function automatic logic [DataW-1:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Operation with the given chances of a push and a pop; the rest are queries and unused codes.
  function automatic logic [OpW-1:0] pick_op(input int push_pct, input int pop_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_pct) return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    if (r < push_pct + pop_pct) return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
    return OpW'($urandom_range(OP_QUERY, 7));
  endfunction

  // Offers one operation beat and waits until it is taken. tvalid stays high
  // between back-to-back beats.
  task automatic send_op(input logic [OpW-1:0] op, input logic [DataW-1:0] word);
    int gap;
    gap = ((sent / 100) % 4 == 3) ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= word;
    do @(posedge clk); while (!s_axis_tready);
    sent++;
    if ((op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && level < Depth) level++;
    if ((op == OP_POP_FRONT || op == OP_POP_BACK) && level > 0) level--;
  endtask

  // Receiver: random stalls, calm stretches, and one long hold-off so that the
  // unit fills up and drops s_axis_tready.
  initial begin
    int  cyc;
    int  gap;
    bit  held;
    cyc  = 0;
    held = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (!held && cyc >= 3000) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk);
        cyc += 300;
        held = 1'b1;
      end else begin
        gap = ((cyc / 256) % 4 == 1) ? 0 : pick_gap();
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk);
          cyc += gap;
        end
        m_axis_tready <= 1'b1;
        @(posedge clk);
        cyc++;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty pops, extreme words at both ends, unused codes,
    // draining to empty and popping once more.
    send_op(OP_QUERY, 32'h1234_5678);
    send_op(OP_POP_FRONT, 32'hdead_beef);
    send_op(OP_POP_BACK, '0);
    send_op(OP_PUSH_FRONT, 32'h7fff_ffff);
    send_op(OP_PUSH_BACK, 32'h8000_0000);
    send_op(OP_PUSH_FRONT, '0);
    send_op(OP_PUSH_BACK, '1);
    send_op(OP_QUERY, '1);
    send_op(3'd5, 32'h0f0f_0f0f);
    send_op(3'd6, 32'hf0f0_f0f0);
    send_op(3'd7, '1);
    send_op(OP_POP_BACK, 32'h5555_5555);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_BACK, '0);
    send_op(OP_POP_BACK, '0);
    send_op(OP_PUSH_BACK, 32'd1);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_PUSH_FRONT, 32'h5555_5555);
    send_op(OP_PUSH_FRONT, 32'haaaa_aaaa);
    send_op(OP_POP_BACK, '0);
    send_op(OP_POP_BACK, '0);

    // Balanced mix around an almost empty queue.
    repeat (250) send_op(pick_op(35, 40), pick_word());

    // Fill to the brim, then keep pushing so that full pushes are refused.
    while (level < Depth) send_op(pick_op(92, 5), pick_word());
    repeat (25) send_op(pick_op(85, 10), pick_word());

    // Drain a good part again, then finish with a mix.
    repeat (300) send_op(pick_op(20, 70), pick_word());
    repeat (100) send_op(pick_op(35, 40), pick_word());
    s_axis_tvalid <= 1'b0;

    // Let the outstanding results come out, then allow for the pipeline depth.
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    if (pending != 0) $error("%0d predicted results never arrived", pending);
    if (mismatch_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #8ms;
    $display("status: fail");
    $finish;
  end

endmodule

[sim.f]
design/deq_pkg.sv
design/deq_front.sv
design/deq_cmd_queue.sv
design/deq_exec.sv
design/double_ended_queue_unit.sv
test/deq_result_checker.sv
test/tb_double_ended_queue_unit.sv
